[design/ehp_pkg.sv]
`timescale 1ns / 1ps
package ehp_pkg;

  localparam int unsigned MaxVlanTags = 2;

  localparam logic [15:0] TypeIpv4 = 16'h0800;
  localparam logic [15:0] TypeVlan = 16'h8100;
  localparam logic [7:0] ProtoTcp = 8'd6;
  localparam logic [7:0] ProtoUdp = 8'd17;
  localparam logic [15:0] TypeThresholdReset = 16'd1536;

  localparam logic [5:0] CodeEnd = 6'd33;

  localparam logic [1:0] StComplete = 2'd0;
  localparam logic [1:0] StTruncated = 2'd1;
  localparam logic [1:0] StLength = 2'd2;
  localparam logic [1:0] StUnhandled = 2'd3;

  localparam logic [2:0] LEth = 3'd0;
  localparam logic [2:0] LVlan = 3'd1;
  localparam logic [2:0] LIp = 3'd2;
  localparam logic [2:0] LIpOpt = 3'd3;
  localparam logic [2:0] LTcp = 3'd4;
  localparam logic [2:0] LUdp = 3'd5;
  localparam logic [2:0] LTcpOpt = 3'd6;
  localparam logic [2:0] LDone = 3'd7;

  // One result record.
  typedef struct packed {
    logic [5:0]  code;
    logic [47:0] value;
    logic        last;
  } rec_t;

  // Up to three records caused by one byte.
  typedef struct packed {
    logic [1:0] count;
    rec_t [2:0] recs;
  } group_t;

endpackage

[design/ehp_if.sv]
`timescale 1ns / 1ps
interface ehp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, data_byte, last_byte, input ready);
  modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface ehp_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  field_code;
  logic [47:0] field_value;
  logic        last_of_run;
  modport source (output valid, field_code, field_value, last_of_run, input ready);
  modport sink (input valid, field_code, field_value, last_of_run, output ready);
endinterface

[design/ethernet_ip_header_parser.sv]
`timescale 1ns / 1ps
// Channel   Dir  Payload
// in_req    in   data_byte, last_byte
// out_req   out  field_code, field_value, last_of_run
// cfg       in   cfg_we_i / cfg_wdata_i (type_threshold)
// One byte is accepted per cycle; its records enter an eight-entry queue in that cycle.
// Records leave one per cycle while out_req is ready, so multi-record bytes slow input.
// Input is held off while fewer than three queue entries are free.
// Reset clears parser state and the queue and sets the threshold to 1536.
module ethernet_ip_header_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  ehp_in_if.sink      in_req,
  ehp_out_if.source   out_req
);
  import ehp_pkg::*;

  logic [15:0] thr_q;
  logic        space, take;
  group_t      grp;

  // Threshold register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) thr_q <= TypeThresholdReset;
    else if (cfg_we_i) thr_q <= cfg_wdata_i;
  end

  assign in_req.ready = space;
  assign take = in_req.valid && space;

  ehp_front u_front (
    .clk_i(clk_i), .rst_ni(rst_ni), .threshold_i(thr_q), .take_i(take),
    .byte_i(in_req.data_byte), .last_i(in_req.last_byte), .group_o(grp)
  );

  ehp_back u_back (
    .clk_i(clk_i), .rst_ni(rst_ni), .group_i(grp), .push_i(take),
    .space_o(space), .out_o(out_req)
  );
endmodule

[design/ehp_front.sv]
`timescale 1ns / 1ps
module ehp_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [15:0]           threshold_i,
  input  logic                  take_i,
  input  logic [7:0]            byte_i,
  input  logic                  last_i,
  output ehp_pkg::group_t       group_o
);
  import ehp_pkg::*;

  logic [2:0]  layer_q, layer_d;
  logic [5:0]  off_q, off_d;
  logic [47:0] acc_q, acc_d, acc;
  logic [3:0]  ihl_q, ihl_d, thl_q, thl_d;
  logic [7:0]  proto_q, proto_d;
  logic [1:0]  vcnt_q, vcnt_d, st_q, st_d;
  group_t      g;
  logic [5:0]  optlen;

  // Parse one byte: next state and the records it yields.
  always_comb begin
    layer_d = layer_q;
    off_d = off_q + 6'd1;
    ihl_d = ihl_q;
    thl_d = thl_q;
    proto_d = proto_q;
    vcnt_d = vcnt_q;
    st_d = st_q;
    acc = {acc_q[39:0], byte_i};
    acc_d = acc;
    g = '0;
    optlen = '0;
    unique case (layer_q)
      LEth: begin
        if (off_q == 6'd5 || off_q == 6'd11 || off_q == 6'd13) begin
          g.recs[0].code = (off_q == 6'd5) ? 6'd0 : (off_q == 6'd11) ? 6'd1 : 6'd2;
          g.recs[0].value = acc;
          g.count = 2'd1;
          acc_d = '0;
        end
      end
      LVlan: begin
        if (off_q == 6'd0) begin
          g.recs[0] = '{6'd3, {45'd0, byte_i[7:5]}, 1'b0};
          g.recs[1] = '{6'd4, {47'd0, byte_i[4]}, 1'b0};
          g.count = 2'd2;
          acc_d = {44'd0, byte_i[3:0]};
        end else if (off_q == 6'd1 || off_q == 6'd3) begin
          g.recs[0].code = (off_q == 6'd1) ? 6'd5 : 6'd6;
          g.recs[0].value = acc;
          g.count = 2'd1;
          acc_d = '0;
        end
      end
      LIp: begin
        case (off_q)
          6'd0: begin
            ihl_d = byte_i[3:0];
            g.recs[0] = '{6'd7, {44'd0, byte_i[7:4]}, 1'b0};
            g.recs[1] = '{6'd8, {44'd0, byte_i[3:0]}, 1'b0};
            g.count = 2'd2;
            acc_d = '0;
          end
          6'd1: begin
            g.recs[0] = '{6'd9, {42'd0, byte_i[7:2]}, 1'b0};
            g.recs[1] = '{6'd10, {46'd0, byte_i[1:0]}, 1'b0};
            g.count = 2'd2;
            acc_d = '0;
          end
          6'd6: begin
            g.recs[0] = '{6'd13, {45'd0, byte_i[7:5]}, 1'b0};
            g.count = 2'd1;
            acc_d = {43'd0, byte_i[4:0]};
          end
          6'd3, 6'd5, 6'd7, 6'd8, 6'd9, 6'd11, 6'd15, 6'd19: begin
            g.recs[0].value = acc;
            g.count = 2'd1;
            acc_d = '0;
            case (off_q)
              6'd3: g.recs[0].code = 6'd11;
              6'd5: g.recs[0].code = 6'd12;
              6'd7: g.recs[0].code = 6'd14;
              6'd8: g.recs[0].code = 6'd15;
              6'd9: g.recs[0].code = 6'd16;
              6'd11: g.recs[0].code = 6'd17;
              6'd15: g.recs[0].code = 6'd18;
              default: g.recs[0].code = 6'd19;
            endcase
            if (off_q == 6'd9) proto_d = byte_i;
          end
          default: ;
        endcase
      end
      LIpOpt: ;
      LTcp: begin
        case (off_q)
          6'd12: begin
            thl_d = byte_i[7:4];
            g.recs[0] = '{6'd24, {44'd0, byte_i[7:4]}, 1'b0};
            g.count = 2'd1;
            acc_d = {47'd0, byte_i[0]};
          end
          6'd1, 6'd3, 6'd7, 6'd11, 6'd13, 6'd15, 6'd17, 6'd19: begin
            g.recs[0].value = acc;
            g.count = 2'd1;
            acc_d = '0;
            case (off_q)
              6'd1: g.recs[0].code = 6'd20;
              6'd3: g.recs[0].code = 6'd21;
              6'd7: g.recs[0].code = 6'd22;
              6'd11: g.recs[0].code = 6'd23;
              6'd13: g.recs[0].code = 6'd25;
              6'd15: g.recs[0].code = 6'd26;
              6'd17: g.recs[0].code = 6'd27;
              default: g.recs[0].code = 6'd28;
            endcase
          end
          default: ;
        endcase
      end
      LTcpOpt: ;
      LUdp: begin
        if (off_q == 6'd1 || off_q == 6'd3 || off_q == 6'd5 || off_q == 6'd7) begin
          g.recs[0].code = 6'd29 + {3'd0, off_q[2:1]};
          g.recs[0].value = acc;
          g.count = 2'd1;
          acc_d = '0;
        end
      end
      default: acc_d = '0;
    endcase

    // Layer transitions after the closing field of each header.
    if ((layer_q == LEth && off_q == 6'd13) || (layer_q == LVlan && off_q == 6'd3)) begin
      off_d = '0;
      acc_d = '0;
      if (acc[15:0] < threshold_i) begin
        st_d = StLength;
        layer_d = LDone;
      end else if (acc[15:0] == TypeIpv4) begin
        layer_d = LIp;
      end else if (acc[15:0] == TypeVlan && {30'd0, vcnt_q} < MaxVlanTags) begin
        vcnt_d = vcnt_q + 2'd1;
        layer_d = LVlan;
      end else begin
        st_d = StUnhandled;
        layer_d = LDone;
      end
    end
    if ((layer_q == LIp && off_q == 6'd19 && ihl_q <= 4'd5) || (layer_q == LIpOpt &&
        (ihl_q <= 4'd5 || off_q + 6'd1 >= {(ihl_q - 4'd5), 2'b00}))) begin
      off_d = '0;
      acc_d = '0;
      if (proto_q == ProtoTcp) layer_d = LTcp;
      else if (proto_q == ProtoUdp) layer_d = LUdp;
      else begin
        st_d = StUnhandled;
        layer_d = LDone;
      end
    end else if (layer_q == LIp && off_q == 6'd19) begin
      off_d = '0;
      acc_d = '0;
      layer_d = LIpOpt;
    end
    optlen = {(thl_q - 4'd5), 2'b00};
    if ((layer_q == LTcp && off_q == 6'd19) || (layer_q == LTcpOpt &&
        (thl_q <= 4'd5 || off_q + 6'd1 >= optlen)) || (layer_q == LUdp && off_q == 6'd7)) begin
      off_d = '0;
      acc_d = '0;
      layer_d = (layer_q == LTcp && thl_q > 4'd5) ? LTcpOpt : LDone;
      if (layer_d == LDone) st_d = StComplete;
    end

    // End record on the final byte, then back to the frame start.
    if (last_i) begin
      g.recs[g.count].code = CodeEnd;
      g.recs[g.count].value = {46'd0, (layer_d == LDone) ? st_d : StTruncated};
      g.count = g.count + 2'd1;
      layer_d = LEth;
      off_d = '0;
      acc_d = '0;
      ihl_d = '0;
      thl_d = '0;
      proto_d = '0;
      vcnt_d = '0;
      st_d = '0;
    end
    if (g.count != 2'd0) g.recs[g.count - 2'd1].last = 1'b1;
  end

  assign group_o = g;

  // Parser state advances on each accepted byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layer_q <= LEth;
      off_q <= '0;
      acc_q <= '0;
      ihl_q <= '0;
      thl_q <= '0;
      proto_q <= '0;
      vcnt_q <= '0;
      st_q <= '0;
    end else if (take_i) begin
      layer_q <= layer_d;
      off_q <= off_d;
      acc_q <= acc_d;
      ihl_q <= ihl_d;
      thl_q <= thl_d;
      proto_q <= proto_d;
      vcnt_q <= vcnt_d;
      st_q <= st_d;
    end
  end

`ifndef SYNTH
  a_vcnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {30'd0, vcnt_q} <= MaxVlanTags) else $error("too many VLAN tags");
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && last_i |=> layer_q == LEth && off_q == 6'd0) else $error("frame not cleared");
  a_end_rec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && last_i |-> g.count != 2'd0) else $error("missing end record");
`endif
endmodule

[design/ehp_back.sv]
`timescale 1ns / 1ps
module ehp_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ehp_pkg::group_t group_i,
  input  logic            push_i,
  output logic            space_o,
  ehp_out_if.source       out_o
);
  import ehp_pkg::*;

  // Record queue: eight entries, up to three written per cycle.
  rec_t       mem_q [8];
  logic [2:0] wp_q, rp_q;
  logic [3:0] cnt_q, cnt_d;
  logic       pop;
  logic [3:0] npush;

  assign npush = push_i ? {2'd0, group_i.count} : 4'd0;
  assign pop = out_o.valid && out_o.ready;
  assign cnt_d = cnt_q + npush - {3'd0, pop};
  assign space_o = (cnt_q <= 4'd5);
  assign out_o.valid = (cnt_q != 4'd0);
  assign out_o.field_code = mem_q[rp_q].code;
  assign out_o.field_value = mem_q[rp_q].value;
  assign out_o.last_of_run = mem_q[rp_q].last;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (push_i && 2'(i) < group_i.count) mem_q[wp_q + 3'(i)] <= group_i.recs[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      wp_q <= wp_q + npush[2:0];
      rp_q <= rp_q + {2'd0, pop};
      cnt_q <= cnt_d;
    end
  end

`ifndef SYNTH
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 4'd8) else $error("queue overflow");
  a_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> space_o) else $error("push without space");
  a_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    3'(wp_q - rp_q) == cnt_q[2:0]) else $error("pointer mismatch");
`endif
endmodule
